/* sv/bounded_deque_with_search_unit_assert.svh */
// Assertion macros shared by the deque unit RTL.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Implication that must hold on every clock edge out of reset.
`define BDQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be seen out of reset.
`define BDQ_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BDQ_ASSERT(lbl, clk, rst, prop, msg)
`define BDQ_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

/* sv/bdq_pkg.sv */
// Shared types and constants of the deque unit.
package bdq_pkg;

  // Default ring depth and cap on the number of words one dump returns.
  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;

  // Operation codes.
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_FIND       = 3'd4;
  localparam logic [2:0] KIND_DUMP_FWD   = 3'd5;
  localparam logic [2:0] KIND_DUMP_REV   = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // What the datapath puts on the result word.
  typedef enum logic [2:0] {
    RES_PLAIN,
    RES_FULL,
    RES_EMPTY,
    RES_POP,
    RES_HIT,
    RES_MISS,
    RES_DUMP
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic rd_next;
    logic push;
    logic pop;
    logic step;
    logic emit;
    logic last;
    res_t res;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       hit;
    logic       scan_end;
    logic       dump_end;
  } sts_t;

endpackage

/* sv/bdq_datapath.sv */
// Ring store, pointers, scan index and result word register of the deque unit.
module bdq_datapath #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bdq_pkg::cmd_t      cmd,
  output bdq_pkg::sts_t      sts,
  input  logic [2:0]         kind,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic signed [31:0] data,
  output logic [3:0]         position,
  output logic [4:0]         length,
  output logic [1:0]         status,
  output logic               last
);
  import bdq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_S   = (CW + 1)'(DEPTH);
  localparam logic [IW-1:0] FRONT_MAX = IW'(DEPTH - 1);

  // front + offset, wrapped once around the ring
  function automatic logic [IW-1:0] ring_add(logic [IW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(off);
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return IW'(s);
  endfunction

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_data;
  logic [2:0]         op;
  logic signed [31:0] val;
  logic [IW-1:0]      front;
  logic [IW-1:0]      front_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      j;
  logic [CW-1:0]      j_inc;
  logic [CW-1:0]      k;
  logic [CW-1:0]      last_slot;
  logic [CW-1:0]      slot_rd;
  logic [CW-1:0]      slot_cur;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      wr_addr;
  logic [IW-1:0]      front_dec;
  logic [IW-1:0]      front_inc;
  logic               rev;
  logic signed [31:0] data_next;
  logic [3:0]         position_next;
  logic [1:0]         status_next;

  // slot addressing: reverse order for pop back and reverse dump
  always_comb begin
    rev       = (op == KIND_POP_BACK) || (op == KIND_DUMP_REV);
    last_slot = count - 1'b1;
    j_inc     = j + 1'b1;
    k         = cmd.rd_next ? j_inc : j;
    slot_rd   = rev ? (last_slot - k) : k;
    slot_cur  = rev ? (last_slot - j) : j;
    rd_addr   = ring_add(front, slot_rd);
    front_dec = (front == '0) ? FRONT_MAX : (front - 1'b1);
    front_inc = (front == FRONT_MAX) ? '0 : (front + 1'b1);
    wr_addr   = (op == KIND_PUSH_FRONT) ? front_dec : ring_add(front, count);
  end

  // pointer updates
  always_comb begin
    count_next = count;
    front_next = front;
    if (cmd.push) begin
      count_next = count + 1'b1;
      if (op == KIND_PUSH_FRONT) front_next = front_dec;
    end else if (cmd.pop) begin
      count_next = count - 1'b1;
      if (op == KIND_POP_FRONT) front_next = front_inc;
    end
  end

  // status back to the controller
  always_comb begin
    sts.op       = op;
    sts.empty    = (count == '0);
    sts.full     = (count == DEPTH_C);
    sts.hit      = (rd_data == val);
    sts.scan_end = (j_inc == count);
    sts.dump_end = (j_inc == count) || (int'(j_inc) == MAX_RESULTS);
  end

  // ring store: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.push) mem[wr_addr] <= val;
    rd_data <= mem[rd_addr];
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

  // operation word and scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= kind;
      val <= value;
      j   <= '0;
    end else if (cmd.step) begin
      j <= j_inc;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  // result word contents by kind of result
  always_comb begin
    data_next     = '0;
    position_next = '0;
    status_next   = ST_OK;
    case (cmd.res)
      RES_FULL:  status_next = ST_FULL;
      RES_EMPTY: status_next = ST_EMPTY;
      RES_MISS:  status_next = ST_NOTFOUND;
      RES_POP:   data_next   = rd_data;
      RES_HIT: begin
        data_next     = val;
        position_next = 4'(j);
      end
      RES_DUMP: begin
        data_next     = rd_data;
        position_next = 4'(slot_cur);
      end
      default: status_next = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      length   <= 5'(count_next);
      last     <= cmd.last;
      data     <= data_next;
      position <= position_next;
      status   <= status_next;
    end
  end

endmodule

/* sv/bdq_ctrl.sv */
// Operation sequencer of the deque unit.
module bdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bdq_pkg::sts_t sts,
  output bdq_pkg::cmd_t cmd
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    cmd.res    = RES_PLAIN;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.push   = !sts.full;
            cmd.res    = sts.full ? RES_FULL : RES_PLAIN;
            state_next = S_IDLE;
          end
          KIND_POP_FRONT, KIND_POP_BACK, KIND_DUMP_FWD, KIND_DUMP_REV: begin
            if (sts.empty) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.res    = RES_EMPTY;
              state_next = S_IDLE;
            end else begin
              state_next = S_SCAN;
            end
          end
          KIND_FIND: begin
            if (sts.empty) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.res    = RES_MISS;
              state_next = S_IDLE;
            end else begin
              state_next = S_SCAN;
            end
          end
          default: begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        // read data holds the entry at the scan index; next one is in flight
        cmd.rd_next = 1'b1;
        case (sts.op)
          KIND_POP_FRONT, KIND_POP_BACK: begin
            cmd.pop    = 1'b1;
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.res    = RES_POP;
            state_next = S_IDLE;
          end
          KIND_FIND: begin
            if (sts.hit) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.res    = RES_HIT;
              state_next = S_IDLE;
            end else if (sts.scan_end) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.res    = RES_MISS;
              state_next = S_IDLE;
            end else begin
              cmd.step = 1'b1;
            end
          end
          KIND_DUMP_FWD, KIND_DUMP_REV: begin
            cmd.emit = 1'b1;
            cmd.last = sts.dump_end;
            cmd.res  = RES_DUMP;
            if (sts.dump_end) begin
              state_next = S_IDLE;
            end else begin
              cmd.step = 1'b1;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

/* sv/bounded_deque_with_search_unit.sv */
// Push, pop: request loaded and decoded, result word registered (pop also reads the store).
// Find: one stored entry compared per cycle; an empty store gives its result from decode.
// Dump: n words (n = entries, at most 16), one word per cycle back to back.
// busy falls in the same cycle as the final word comes out, and the next
// operation may be accepted in that cycle.
// Synchronous reset empties the queue; store contents are not cleared.
`include "bounded_deque_with_search_unit_assert.svh"

module bounded_deque_with_search_unit #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic signed [31:0] data,
  output logic [3:0]         position,
  output logic [4:0]         length,
  output logic [1:0]         status,
  output logic               last
);
  import bdq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  bdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // store and result word
  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .kind     (kind),
    .value    (value),
    .strobe   (strobe),
    .data     (data),
    .position (position),
    .length   (length),
    .status   (status),
    .last     (last)
  );

  // checks
  `BDQ_ASSERT(a_accept_no_word, clk, rst, (start && !busy) |=> (busy && !strobe), "early word")
  `BDQ_NEVER(a_last_while_busy, clk, rst, (strobe && last && busy), "busy after final word")
  `BDQ_ASSERT(a_dump_contiguous, clk, rst, (strobe && !last) |=> strobe, "gap in dump")
  `BDQ_ASSERT(a_word_from_busy, clk, rst, strobe |-> $past(busy), "word without an operation")

endmodule
